// File: design/ilfr_pkg.sv
// Shared types and constants for the ID/length frame receiver.
`default_nettype none

package ilfr_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int QDEPTH           = 2;
    localparam int CNT_W            = 8;

    localparam logic [1:0] EV_CMD   = 2'd0;
    localparam logic [1:0] EV_BYTE  = 2'd1;
    localparam logic [1:0] EV_EMPTY = 2'd2;

    localparam logic [2:0] CFG_FIRST_ID      = 3'd0;
    localparam logic [2:0] CFG_FIRST_LENGTH  = 3'd1;
    localparam logic [2:0] CFG_SECOND_ID     = 3'd2;
    localparam logic [2:0] CFG_SECOND_LENGTH = 3'd3;
    localparam logic [2:0] CFG_END_BYTE      = 3'd4;

    typedef enum logic [1:0] {
        OP_CMD,
        OP_STORE,
        OP_DRAIN,
        OP_EMPTY
    } op_t;

    // cnt: store address for OP_STORE, payload byte count for OP_DRAIN
    typedef struct packed {
        op_t              op;
        logic [7:0]       data;
        logic [CNT_W-1:0] cnt;
    } q_entry_t;

    typedef struct packed {
        logic [7:0] first_id;
        logic [6:0] first_length;
        logic [7:0] second_id;
        logic [6:0] second_length;
        logic [7:0] end_byte;
    } cfg_t;

endpackage

`default_nettype wire

// File: design/ilfr_front.sv
// Front end: frame tracking and byte classification into queue requests.
`default_nettype none

module ilfr_front
    import ilfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire logic     in_valid,
    input  wire logic     q_full,
    input  wire logic [7:0] rx_byte,
    output logic          in_stall,
    output logic          q_push,
    output q_entry_t      q_entry
);

    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int FLW = $clog2(BUFFER_DEPTH + 1);

    logic [FLW-1:0] frame_len_reg, frame_len_next;
    logic [AW-1:0]  byte_cnt_reg, byte_cnt_next;
    logic           accept;

    function automatic logic [FLW-1:0] clamp_len(input logic [6:0] len);
        logic [FLW-1:0] res;
        if (32'(len) > BUFFER_DEPTH) begin
            res = FLW'(BUFFER_DEPTH);
        end
        else begin
            res = FLW'(len);
        end
        return res;
    endfunction

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        frame_len_next = frame_len_reg;
        byte_cnt_next  = byte_cnt_reg;
        q_push         = 1'b0;
        q_entry.op     = OP_STORE;
        q_entry.data   = rx_byte;
        q_entry.cnt    = CNT_W'(byte_cnt_reg);
        if (accept) begin
            if (frame_len_reg == '0) begin
                byte_cnt_next = '0;
                if (rx_byte == cfg.first_id) begin
                    frame_len_next = clamp_len(cfg.first_length);
                    q_push         = 1'b1;
                    q_entry.op     = OP_CMD;
                end
                else if (rx_byte == cfg.second_id) begin
                    frame_len_next = clamp_len(cfg.second_length);
                    q_push         = 1'b1;
                    q_entry.op     = OP_CMD;
                end
            end
            else if (32'(byte_cnt_reg) + 1 >= 32'(frame_len_reg)) begin
                // terminator position
                if (rx_byte == cfg.end_byte) begin
                    q_push     = 1'b1;
                    q_entry.op = (byte_cnt_reg == '0) ? OP_EMPTY : OP_DRAIN;
                end
                frame_len_next = '0;
                byte_cnt_next  = '0;
            end
            else begin
                q_push        = 1'b1;
                q_entry.op    = OP_STORE;
                byte_cnt_next = byte_cnt_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_len_reg <= '0;
            byte_cnt_reg  <= '0;
        end
        else begin
            frame_len_reg <= frame_len_next;
            byte_cnt_reg  <= byte_cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: design/ilfr_queue.sv
// Short request queue between front and back ends.
`default_nettype none

module ilfr_queue
    import ilfr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t push_entry,
    input  wire logic     pop,
    output logic          full,
    output logic          not_empty,
    output q_entry_t      head
);

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    q_entry_t        slots_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full      = (32'(count_reg) == QDEPTH);
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == QDEPTH - 1) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == QDEPTH - 1) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: design/ilfr_back.sv
// Back end: payload buffer, drain sequencer and output register.
`default_nettype none

module ilfr_back
    import ilfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     q_valid,
    input  wire q_entry_t q_head,
    input  wire logic     out_stall,
    output logic          q_pop,
    output logic          out_valid,
    output logic [1:0]    event_res,
    output logic [7:0]    value,
    output logic          last_of_run
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   drain_idx_reg, drain_idx_next;
    logic [AW-1:0]   drain_last_reg, drain_last_next;
    logic            out_valid_reg, out_valid_next;
    logic [1:0]      ev_reg, ev_next;
    logic [7:0]      val_reg, val_next;
    logic            last_reg, last_next;

    logic [7:0]      mem [BUFFER_DEPTH];
    logic [7:0]      rd_data_reg;
    logic            mem_we;
    logic            out_free;
    logic [CNT_W-1:0] cnt_m1;

    assign out_free = !out_valid_reg || !out_stall;
    assign cnt_m1   = q_head.cnt - CNT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        drain_idx_next  = drain_idx_reg;
        drain_last_next = drain_last_reg;
        out_valid_next  = out_valid_reg && out_stall;
        ev_next         = ev_reg;
        val_next        = val_reg;
        last_next       = last_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid) begin
                    case (q_head.op)
                        OP_STORE:
                        begin
                            mem_we = 1'b1;
                            q_pop  = 1'b1;
                        end
                        OP_CMD:
                        begin
                            if (out_free) begin
                                q_pop          = 1'b1;
                                out_valid_next = 1'b1;
                                ev_next        = EV_CMD;
                                val_next       = q_head.data;
                                last_next      = 1'b1;
                            end
                        end
                        OP_EMPTY:
                        begin
                            if (out_free) begin
                                q_pop          = 1'b1;
                                out_valid_next = 1'b1;
                                ev_next        = EV_EMPTY;
                                val_next       = 8'd0;
                                last_next      = 1'b1;
                            end
                        end
                        OP_DRAIN:
                        begin
                            q_pop           = 1'b1;
                            drain_idx_next  = '0;
                            drain_last_next = cnt_m1[AW-1:0];
                            state_next      = S_READ;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    ev_next        = EV_BYTE;
                    val_next       = rd_data_reg;
                    last_next      = (drain_idx_reg == drain_last_reg);
                    if (drain_idx_reg == drain_last_reg) begin
                        state_next = S_IDLE;
                    end
                    else begin
                        drain_idx_next = drain_idx_reg + AW'(1);
                        state_next     = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            drain_idx_reg  <= '0;
            drain_last_reg <= '0;
            out_valid_reg  <= 1'b0;
            ev_reg         <= EV_CMD;
            val_reg        <= 8'd0;
            last_reg       <= 1'b0;
        end
        else begin
            state_reg      <= state_next;
            drain_idx_reg  <= drain_idx_next;
            drain_last_reg <= drain_last_next;
            out_valid_reg  <= out_valid_next;
            ev_reg         <= ev_next;
            val_reg        <= val_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[q_head.cnt[AW-1:0]] <= q_head.data;
        end
        rd_data_reg <= mem[drain_idx_reg];
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = ev_reg;
    assign value       = val_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

// File: design/id_length_frame_receiver.sv
// Top level of the ID/length frame receiver: config registers, front, queue, back.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  rx      | in_valid, in_stall, rx_byte              | in
//  result  | out_valid, out_stall, event_res, value,  | out
//          | last_of_run                              |
//  config  | cfg_valid, cfg_ready, cfg_index,cfg_data | in
//
// While the queue is not full, the front classifies one byte per cycle into a
// request; the queue holds two. The back end takes one request at a time; a
// drain reads each of its N payload bytes by a registered buffer read.
// in_stall rises while the request queue is full, e.g. during a drain.
// Reset clears frame tracking, queue and output valid; buffer is not cleared.
`default_nettype none

module id_length_frame_receiver
    import ilfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      event_res,
    output logic [7:0]      value,
    output logic            last_of_run,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    cfg_t     cfg_reg;
    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     q_valid;
    q_entry_t q_in;
    q_entry_t q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.first_id      <= 8'd0;
            cfg_reg.first_length  <= 7'd1;
            cfg_reg.second_id     <= 8'd1;
            cfg_reg.second_length <= 7'd1;
            cfg_reg.end_byte      <= 8'd10;
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FIRST_ID:      cfg_reg.first_id      <= cfg_data;
                CFG_FIRST_LENGTH:  cfg_reg.first_length  <= cfg_data[6:0];
                CFG_SECOND_ID:     cfg_reg.second_id     <= cfg_data;
                CFG_SECOND_LENGTH: cfg_reg.second_length <= cfg_data[6:0];
                CFG_END_BYTE:      cfg_reg.end_byte      <= cfg_data;
                default:           ;
            endcase
        end
    end

    ilfr_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .q_full   (q_full),
        .rx_byte  (rx_byte),
        .in_stall (in_stall),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    ilfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    ilfr_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .out_stall   (out_stall),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .event_res   (event_res),
        .value       (value),
        .last_of_run (last_of_run)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("request pushed into full queue");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("request popped from empty queue");

    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_EMPTY |-> value == 8'd0 && last_of_run)
        else $error("empty-frame result malformed");

    a_cmd_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_CMD |-> last_of_run)
        else $error("command result not marked last");

endmodule

`default_nettype wire

// File: tb/id_length_frame_receiver_test.sv
// Self-checking testbench for the ID/length frame receiver: directed table, then random frames.
module id_length_frame_receiver_test;
    import ilfr_pkg::*;

    typedef struct packed {
        logic [1:0] ev;
        logic [7:0] data;
        logic       last_flag;
    } result_t;

    typedef struct {
        bit         is_cfg;
        logic [7:0] b;
        int         typed_n;
        logic [1:0] ev;
        logic [7:0] val;
    } stim_row_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] event_res;
    logic [7:0] value;
    logic       last_of_run;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = 3'd0;
    logic [7:0] cfg_data  = 8'h00;

    id_length_frame_receiver DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_res   (event_res),
        .value       (value),
        .last_of_run (last_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // frame tracking copy
    cfg_t       rx_cfg;
    logic [6:0] fr_len;
    logic [6:0] fr_count;
    logic [7:0] payload_copy [BUFFER_DEPTH_DEF];

    result_t   frame_results[$];
    result_t   expected_results[$];
    stim_row_t stim_rows[$];
    logic [7:0] dir_cfg [3][5];

    int send_pct = 0;
    int recv_pct = 0;
    int mismatch_count = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int frames_done = 0;
    int frames_dropped = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("id_length_frame_receiver_test NOT OK");
        $finish;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_pct);
    end

    function automatic logic [6:0] clamp_len(input logic [6:0] l);
        return (l > BUFFER_DEPTH_DEF) ? 7'(BUFFER_DEPTH_DEF) : l;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        int i;
        frame_results.delete();
        if (fr_len == 0)
        begin
            fr_count = 0;
            if (b == rx_cfg.first_id)
                fr_len = clamp_len(rx_cfg.first_length);
            else if (b == rx_cfg.second_id)
                fr_len = clamp_len(rx_cfg.second_length);
            else
                return;
            frame_results.push_back(result_t'{EV_CMD, b, 1'b1});
            return;
        end
        if (fr_count + 1 >= fr_len)
        begin
            if (b == rx_cfg.end_byte)
            begin
                frames_done++;
                if (fr_count == 0)
                    frame_results.push_back(result_t'{EV_EMPTY, 8'h00, 1'b1});
                else
                    for (i = 0; i < fr_count; i++)
                        frame_results.push_back(result_t'{EV_BYTE, payload_copy[i],
                                                          (i + 1 == fr_count)});
            end
            else
                frames_dropped++;
            fr_len = 0;
            fr_count = 0;
            return;
        end
        if (fr_count < BUFFER_DEPTH_DEF)
        begin
            payload_copy[fr_count] = b;
            fr_count++;
        end
    endfunction

    function automatic logic [7:0] pick_len();
        int r;
        logic [6:0] l;
        r = $urandom_range(99);
        if (r < 8)
            l = 7'd0;
        else if (r < 16)
            l = 7'($urandom_range(127, 60));
        else
            l = 7'($urandom_range(8, 1));
        return {1'($urandom_range(1)), l};
    endfunction

    task automatic add_row(input bit is_cfg, input logic [7:0] b, input int typed_n = -1,
                           input logic [1:0] ev = EV_CMD, input logic [7:0] val = 8'h00);
        stim_rows.push_back('{is_cfg, b, typed_n, ev, val});
    endtask

    // typed_n: -1 take the predicted results, otherwise the typed-in result count (0 or 1)
    task automatic send_byte(input logic [7:0] b, input int typed_n = -1,
                             input logic [1:0] tev = EV_CMD, input logic [7:0] tval = 8'h00);
        if ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_pct);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
        deframe_byte(b);
        if (typed_n < 0)
            foreach (frame_results[k])
                expected_results.push_back(frame_results[k]);
        else if (typed_n == 1)
            expected_results.push_back(result_t'{tev, tval, 1'b1});
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // writes all five registers, then one unused index
    task automatic set_config(input logic [7:0] v0, input logic [7:0] v1, input logic [7:0] v2,
                              input logic [7:0] v3, input logic [7:0] v4);
        logic [7:0] vals [6];
        logic [2:0] idx;
        int i;
        vals = '{v0, v1, v2, v3, v4, 8'($urandom_range(255))};
        for (i = 0; i < 6; i++)
        begin
            idx = (i < 5) ? 3'(i) : 3'(5 + $urandom_range(2));
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            cfg_writes++;
            case (idx)
                CFG_FIRST_ID:      rx_cfg.first_id      = vals[i];
                CFG_FIRST_LENGTH:  rx_cfg.first_length  = vals[i][6:0];
                CFG_SECOND_ID:     rx_cfg.second_id     = vals[i];
                CFG_SECOND_LENGTH: rx_cfg.second_length = vals[i][6:0];
                CFG_END_BYTE:      rx_cfg.end_byte      = vals[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, got event %0d value %02h last %0d",
                         $time, event_res, value, last_of_run);
            end
            else
            begin
                want = expected_results.pop_front();
                if (event_res !== want.ev)
                begin
                    mismatch_count++;
                    $display("%0t: event_res expected %0d, got %0d", $time, want.ev, event_res);
                end
                if (value !== want.data)
                begin
                    mismatch_count++;
                    $display("%0t: value expected %02h, got %02h", $time, want.data, value);
                end
                if (last_of_run !== want.last_flag)
                begin
                    mismatch_count++;
                    $display("%0t: last_of_run expected %0d, got %0d",
                             $time, want.last_flag, last_of_run);
                end
            end
        end
    end

    initial
    begin
        int ph;
        int phase_cnt;
        int sub_end;
        int r;
        int n;
        int j;
        logic [7:0] b;
        logic [7:0] fid;
        logic [7:0] sid;

        rx_cfg = '{first_id: 8'd0, first_length: 7'd1, second_id: 8'd1,
                   second_length: 7'd1, end_byte: 8'd10};
        fr_len = 0;
        fr_count = 0;

        dir_cfg = '{'{8'hFF, 8'h04, 8'h00, 8'h00, 8'h00},
                    '{8'h3C, 8'h02, 8'h3C, 8'hFF, 8'hA5},
                    '{8'h80, 8'h01, 8'h7F, 8'h82, 8'h80}};

        // reset settings
        add_row(0, 8'h00, 1, EV_CMD, 8'h00);
        add_row(0, 8'h0A, 1, EV_EMPTY, 8'h00);
        add_row(0, 8'h01, 1, EV_CMD, 8'h01);
        add_row(0, 8'h55, 0);
        add_row(0, 8'hFF, 0);
        // zero-length second type, four-byte first type, terminator 0
        add_row(1, 8'd0);
        add_row(0, 8'h00, 1, EV_CMD, 8'h00);
        add_row(0, 8'h00, 1, EV_CMD, 8'h00);
        add_row(0, 8'hFF, 1, EV_CMD, 8'hFF);
        add_row(0, 8'h00);
        add_row(0, 8'hFF);
        add_row(0, 8'h5A);
        add_row(0, 8'h00);
        add_row(0, 8'hFF, 1, EV_CMD, 8'hFF);
        add_row(0, 8'h12);
        add_row(0, 8'h34);
        add_row(0, 8'h56);
        add_row(0, 8'h99, 0);
        // both IDs equal: first type wins
        add_row(1, 8'd1);
        add_row(0, 8'h3C, 1, EV_CMD, 8'h3C);
        add_row(0, 8'hC3);
        add_row(0, 8'hA5);
        add_row(1, 8'd2);
        add_row(0, 8'h7F, 1, EV_CMD, 8'h7F);
        add_row(0, 8'h80);
        add_row(0, 8'h80);
        add_row(0, 8'h80, 1, EV_CMD, 8'h80);
        add_row(0, 8'h80, 1, EV_EMPTY, 8'h00);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pct = 33;
        recv_pct = 75;
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].is_cfg)
            begin
                wait_drained();
                set_config(dir_cfg[stim_rows[i].b][0], dir_cfg[stim_rows[i].b][1],
                           dir_cfg[stim_rows[i].b][2], dir_cfg[stim_rows[i].b][3],
                           dir_cfg[stim_rows[i].b][4]);
            end
            else
                send_byte(stim_rows[i].b, stim_rows[i].typed_n, stim_rows[i].ev,
                          stim_rows[i].val);
        end

        for (ph = 0; ph < 3; ph++)
        begin
            send_pct = (ph == 0) ? 33 : (ph == 1) ? 75 : 0;
            recv_pct = (ph == 0) ? 75 : (ph == 1) ? 33 : 0;
            phase_cnt = 0;
            while (phase_cnt < 60)
            begin
                wait_drained();
                if (phase_cnt == 0 && ph == 0)
                    set_config(8'h00, 8'h81, 8'hFF, 8'h40, 8'hFF);
                else if (phase_cnt == 0 && ph == 1)
                    set_config(8'hFF, 8'h7F, 8'h00, 8'h00, 8'h00);
                else
                begin
                    fid = 8'($urandom_range(255));
                    sid = ($urandom_range(99) < 15) ? fid : 8'($urandom_range(255));
                    set_config(fid, pick_len(), sid, pick_len(), 8'($urandom_range(255)));
                end
                sub_end = phase_cnt + 15 + $urandom_range(15);
                while (phase_cnt < sub_end)
                begin
                    r = $urandom_range(99);
                    if (r < 15)
                    begin
                        // noise that matches neither ID
                        do b = 8'($urandom_range(255));
                        while (b == rx_cfg.first_id || b == rx_cfg.second_id);
                        send_byte(b);
                    end
                    else
                    begin
                        send_byte($urandom_range(1) ? rx_cfg.first_id : rx_cfg.second_id);
                        phase_cnt++;
                        n = fr_len;
                        if (n > 0)
                        begin
                            for (j = 0; j < n - 1; j++)
                                send_byte(8'($urandom_range(255)));
                            if (r < 25)
                            begin
                                do b = 8'($urandom_range(255)); while (b == rx_cfg.end_byte);
                            end
                            else
                                b = rx_cfg.end_byte;
                            send_byte(b);
                            phase_cnt += n;
                        end
                    end
                end
            end
        end

        wait_drained();
        $display("Sent %0d bytes: %0d frames completed, %0d dropped, %0d register writes",
                 bytes_sent, frames_done, frames_dropped, cfg_writes);
        $display("Checked %0d results under three stall mixes", results_seen);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("id_length_frame_receiver_test OK");
        else
            $display("id_length_frame_receiver_test NOT OK");
        $finish;
    end

endmodule

// File: id_length_frame_receiver.f
design/ilfr_pkg.sv
design/ilfr_front.sv
design/ilfr_queue.sv
design/ilfr_back.sv
design/id_length_frame_receiver.sv
tb/id_length_frame_receiver_test.sv
